[src/fifo_with_running_max_core_defines.svh]
// Assertion macros used by the bound property checker in src/fifomax_checker.sv.
`ifndef FIFO_WITH_RUNNING_MAX_CORE_DEFINES_SVH
`define FIFO_WITH_RUNNING_MAX_CORE_DEFINES_SVH

// same-cycle implication
`define FIFOMAX_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FIFOMAX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/fifomax_pkg.sv]
`timescale 1ns / 1ps

package fifomax_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;

   localparam logic signed [VALUE_W-1:0] MIN_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DEQ_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ENQ_FULL  = 2'd2;

   // one cell's contents: entry plus max of this entry and all younger ones
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
      logic signed [VALUE_W-1:0] max;
   } fifomax_slot_type;

   // broadcast to every cell
   typedef struct packed {
      logic                      enq;
      logic                      deq;
      logic signed [VALUE_W-1:0] value;
   } fifomax_op_type;

   localparam fifomax_slot_type SLOT_EMPTY = '0;

endpackage

[src/fifomax_cell.sv]
`timescale 1ns / 1ps

module fifomax_cell
   import fifomax_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  fifomax_op_type   op,
   input  logic             prev_valid,
   input  fifomax_slot_type next_slot,
   output fifomax_slot_type slot
);

   logic                      valid_ff, valid_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic signed [VALUE_W-1:0] max_ff, max_in;

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      max_in   = max_ff;
      if (op.deq) begin
         valid_in = next_slot.valid;
         value_in = next_slot.value;
         max_in   = next_slot.max;
      end else if (op.enq) begin
         if (!valid_ff && prev_valid) begin
            valid_in = 1'b1;
            value_in = op.value;
            max_in   = op.value;
         end else if (valid_ff && (op.value > max_ff)) begin
            max_in = op.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      max_ff   <= max_in;
   end

   assign slot.valid = valid_ff;
   assign slot.value = value_ff;
   assign slot.max   = max_ff;

endmodule

[src/fifo_with_running_max_core.sv]
`timescale 1ns / 1ps

// Bounded FIFO of signed 32-bit values that also reports the largest value held.
// Each request beat enqueues req_value (command 0) or dequeues the oldest entry
// (command 1); each produces one response beat with the dequeued value, the max
// after the step (most negative value when empty), an empty flag, the occupancy
// and a status (dequeue from empty and enqueue when full change nothing). Storage
// is a row of DEPTH cells, oldest at cell 0; each cell keeps its entry and the max
// of itself and all younger entries, so the max of all entries sits at cell 0. A dequeue
// shifts every cell one step toward the head; an enqueue lands in the first empty
// cell and updates the running max of all occupied cells in the same cycle. One
// beat is taken per clock unless a response waits untaken (one being taken does
// not block); the response is registered and valid in the cycle after the request.
module fifo_with_running_max_core
   import fifomax_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int OCC_W = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_command,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_dequeued_value,
   output logic signed [VALUE_W-1:0] rsp_current_max,
   output logic                      rsp_is_empty,
   output logic [OCC_W-1:0]          rsp_occupancy,
   output logic [STATUS_W-1:0]       rsp_status
);

   fifomax_slot_type slots [DEPTH];
   fifomax_op_type   op;

   logic accept, is_deq, full, empty, enq_ok, deq_ok;

   logic [OCC_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] deq_value_ff, deq_value_in;
   logic signed [VALUE_W-1:0] max_ff, max_in;
   logic [STATUS_W-1:0]       status_ff, status_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_deq    = (req_command == CMD_DEQ);
   assign full      = slots[DEPTH-1].valid;
   assign empty     = !slots[0].valid;
   assign enq_ok    = accept && !is_deq && !full;
   assign deq_ok    = accept && is_deq && !empty;

   assign op.enq   = enq_ok;
   assign op.deq   = deq_ok;
   assign op.value = req_value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic             prev_valid;
      fifomax_slot_type next_slot;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
      end else begin : g_body
         assign prev_valid = slots[i-1].valid;
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_slot = SLOT_EMPTY;
      end else begin : g_link
         assign next_slot = slots[i+1];
      end

      fifomax_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (op),
         .prev_valid (prev_valid),
         .next_slot  (next_slot),
         .slot       (slots[i])
      );
   end

   always_comb begin
      count_in     = count_ff;
      deq_value_in = '0;
      status_in    = ST_OK;
      max_in       = empty ? MIN_VALUE : slots[0].max;
      if (enq_ok) begin
         count_in = count_ff + OCC_W'(1);
         if (empty || (req_value > slots[0].max)) begin
            max_in = req_value;
         end
      end else if (deq_ok) begin
         count_in     = count_ff - OCC_W'(1);
         deq_value_in = slots[0].value;
         max_in       = slots[1].valid ? slots[1].max : MIN_VALUE;
      end else if (is_deq) begin
         status_in = ST_DEQ_EMPTY;
      end else begin
         status_in = ST_ENQ_FULL;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         deq_value_ff <= deq_value_in;
         max_ff       <= max_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dequeued_value = deq_value_ff;
   assign rsp_current_max    = max_ff;
   assign rsp_occupancy      = count_ff;
   assign rsp_is_empty       = (count_ff == '0);
   assign rsp_status         = status_ff;

endmodule

[src/fifomax_checker.sv]
`timescale 1ns / 1ps

`include "fifo_with_running_max_core_defines.svh"

module fifomax_props
   import fifomax_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int OCC_W = $clog2(DEPTH + 1)
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [VALUE_W-1:0] rsp_dequeued_value,
   input logic signed [VALUE_W-1:0] rsp_current_max,
   input logic                      rsp_is_empty,
   input logic [OCC_W-1:0]          rsp_occupancy,
   input logic [STATUS_W-1:0]       rsp_status
);

   `FIFOMAX_ASSERT_NOW(a_empty_max, rsp_valid && rsp_is_empty, rsp_current_max == MIN_VALUE, "empty beat without min max")
   `FIFOMAX_ASSERT_NOW(a_empty_occ, rsp_valid, rsp_is_empty == (rsp_occupancy == '0), "empty flag disagrees with occupancy")
   `FIFOMAX_ASSERT_NOW(a_fail_zero, rsp_valid && (rsp_status != ST_OK), rsp_dequeued_value == '0, "failed beat carries data")
   `FIFOMAX_ASSERT_NEXT(a_req_rsp, req_valid && req_ready, rsp_valid, "request beat without response")
   `FIFOMAX_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response beat dropped")

endmodule

bind fifo_with_running_max_core fifomax_props #(.DEPTH(DEPTH)) u_checker (.*);

[tb/fifomax_checker.sv]
`timescale 1ns / 1ps

module fifomax_checker
   import fifomax_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int OCC_W = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_command,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [VALUE_W-1:0] rsp_dequeued_value,
   input  logic signed [VALUE_W-1:0] rsp_current_max,
   input  logic                      rsp_is_empty,
   input  logic [OCC_W-1:0]          rsp_occupancy,
   input  logic [STATUS_W-1:0]       rsp_status,
   output int unsigned               mismatch_count,
   output int unsigned               pending_count,
   output int unsigned               checked_count,
   output int unsigned               full_hits,
   output int unsigned               empty_hits
);

   typedef struct {
      logic signed [VALUE_W-1:0] dequeued;
      logic signed [VALUE_W-1:0] peak;
      logic                      empty;
      logic [OCC_W-1:0]          occ;
      logic [STATUS_W-1:0]       status;
   } step_result_type;

   logic signed [VALUE_W-1:0] held_q[$];   // values in arrival order
   logic signed [VALUE_W-1:0] peak_q[$];   // non-increasing max candidates
   step_result_type           awaited_q[$];
   step_result_type           want;
   int unsigned               errs = 0;
   int unsigned               seen = 0;
   int unsigned               n_full = 0;
   int unsigned               n_empty = 0;

   function automatic step_result_type apply_beat(logic cmd, logic signed [VALUE_W-1:0] v);
      step_result_type r;
      r.dequeued = '0;
      r.status   = ST_OK;
      if (cmd == CMD_ENQ) begin
         if (held_q.size() >= DEPTH) begin
            r.status = ST_ENQ_FULL;
         end else begin
            held_q.push_back(v);
            // only strictly smaller candidates drop out; equal ones stay
            while (peak_q.size() > 0 && peak_q[$] < v)
               void'(peak_q.pop_back());
            peak_q.push_back(v);
         end
      end else begin
         if (held_q.size() == 0) begin
            r.status = ST_DEQ_EMPTY;
         end else begin
            r.dequeued = held_q.pop_front();
            if (peak_q.size() > 0 && peak_q[0] == r.dequeued)
               void'(peak_q.pop_front());
         end
      end
      r.peak  = (peak_q.size() > 0) ? peak_q[0] : MIN_VALUE;
      r.empty = (held_q.size() == 0);
      r.occ   = OCC_W'(held_q.size());
      return r;
   endfunction

   task automatic check_field(input string field, input logic signed [VALUE_W-1:0] exp_v,
                              input logic signed [VALUE_W-1:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", field, exp_v, got_v);
         errs++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_q.delete();
         peak_q.delete();
         awaited_q.delete();
      end else begin
         // response first: it belongs to a beat taken on an earlier edge
         if (rsp_valid && rsp_ready) begin
            if (awaited_q.size() == 0) begin
               $error("response beat with no request outstanding");
               errs++;
            end else begin
               want = awaited_q.pop_front();
               seen++;
               check_field("dequeued_value", want.dequeued, rsp_dequeued_value);
               check_field("current_max", want.peak, rsp_current_max);
               check_field("is_empty", VALUE_W'(want.empty), VALUE_W'(rsp_is_empty));
               check_field("occupancy", VALUE_W'(want.occ), VALUE_W'(rsp_occupancy));
               check_field("status", VALUE_W'(want.status), VALUE_W'(rsp_status));
            end
         end
         if (req_valid && req_ready) begin
            want = apply_beat(req_command, req_value);
            if (want.status == ST_ENQ_FULL)
               n_full++;
            if (want.status == ST_DEQ_EMPTY)
               n_empty++;
            awaited_q.push_back(want);
         end
      end
      mismatch_count <= errs;
      pending_count  <= awaited_q.size();
      checked_count  <= seen;
      full_hits      <= n_full;
      empty_hits     <= n_empty;
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
   import fifomax_pkg::*;
;

   localparam int OCC_W      = $clog2(DEPTH_DEFAULT + 1);
   localparam int N_ITEMS    = 1400;
   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_WAIT  = 10;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_type;
   typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_command = CMD_ENQ;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_dequeued_value;
   logic signed [VALUE_W-1:0] rsp_current_max;
   logic                      rsp_is_empty;
   logic [OCC_W-1:0]          rsp_occupancy;
   logic [STATUS_W-1:0]       rsp_status;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned checked_count;
   int unsigned full_hits;
   int unsigned empty_hits;

   int unsigned sent_count = 0;
   int unsigned burst_left = 0;
   int unsigned idle_cycles = 0;
   rx_mode_type rx_mode = RX_OPEN;
   int unsigned rx_left = 0;

   fifo_with_running_max_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_dequeued_value (rsp_dequeued_value),
      .rsp_current_max    (rsp_current_max),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_status         (rsp_status)
   );

   fifomax_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_dequeued_value (rsp_dequeued_value),
      .rsp_current_max    (rsp_current_max),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_status         (rsp_status),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .checked_count      (checked_count),
      .full_hits          (full_hits),
      .empty_hits         (empty_hits)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver: random-length stretches of open, coin-flip, sparse and held-off ready
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(8, 80);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ready <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(0, 7))
         0:       v = MIN_VALUE;
         1:       v = ~MIN_VALUE;
         2:       v = MIN_VALUE + $urandom_range(0, 3);
         3:       v = ~MIN_VALUE - $urandom_range(0, 3);
         4, 5:    v = $signed($urandom_range(0, 8)) - 4;   // dense duplicates
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_beat(input logic cmd, input logic signed [VALUE_W-1:0] v);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= v;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // hold off until every outstanding response has been taken
   task automatic drain_wait();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   initial begin
      phase_type   phase;
      int unsigned len;
      logic        cmd;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners, duplicates of the max, dequeue from empty
      send_beat(CMD_DEQ, '0);
      send_beat(CMD_ENQ, MIN_VALUE);
      send_beat(CMD_ENQ, ~MIN_VALUE);
      send_beat(CMD_ENQ, ~MIN_VALUE);
      send_beat(CMD_ENQ, '0);
      send_beat(CMD_ENQ, -1);
      send_beat(CMD_ENQ, 5);
      send_beat(CMD_ENQ, 32'sh5555_5555);
      send_beat(CMD_ENQ, 32'shAAAA_AAAA);
      repeat (8) send_beat(CMD_DEQ, $urandom);
      send_beat(CMD_DEQ, '1);
      send_beat(CMD_ENQ, 7);
      send_beat(CMD_ENQ, 7);
      send_beat(CMD_ENQ, 3);
      repeat (4) send_beat(CMD_DEQ, '0);
      drain_wait();

      while (sent_count < N_ITEMS) begin
         phase = phase_type'($urandom_range(0, 2));
         len = (phase == PH_MIXED) ? $urandom_range(10, 60) : $urandom_range(60, 140);
         repeat (len) begin
            case (phase)
               PH_FILL:  cmd = ($urandom_range(0, 99) < 85) ? CMD_ENQ : CMD_DEQ;
               PH_DRAIN: cmd = ($urandom_range(0, 99) < 85) ? CMD_DEQ : CMD_ENQ;
               default:  cmd = 1'($urandom_range(0, 1));
            endcase
            send_beat(cmd, (cmd == CMD_ENQ) ? pick_value() : $urandom);
         end
         if ($urandom_range(0, 5) == 0)
            drain_wait();
      end

      drain_wait();
      repeat (TAIL_WAIT) @(posedge clock);

      $display("%0d request beats sent, %0d responses checked", sent_count, checked_count);
      $display("enqueue-when-full seen %0d times, dequeue-from-empty %0d times",
               full_hits, empty_hits);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
